>>> hdl/deq_pkg.sv
// Package with the types, constants and sizes of the double-ended queue.
package deq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int SUM_W      = IDX_W + 1;

  localparam logic [IDX_W-1:0] LAST_IDX  = IDX_W'(DEPTH - 1);
  localparam logic [CNT_W-1:0] FULL_CNT  = CNT_W'(DEPTH);
  localparam logic [SUM_W-1:0] DEPTH_SUM = SUM_W'(DEPTH);

  typedef enum logic [1:0] {
    OP_PUSH_FRONT = 2'd0,
    OP_PUSH_REAR  = 2'd1,
    OP_POP_FRONT  = 2'd2,
    OP_POP_REAR   = 2'd3
  } op_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    op_e                           op;
    logic signed [DATA_WIDTH-1:0]  push_value;
  } deq_req_t;

  typedef struct packed {
    logic signed [DATA_WIDTH-1:0]  pop_value;
    status_e                       status;
    logic [CNT_W-1:0]              occupancy;
  } deq_rsp_t;

  typedef struct packed {
    logic                   we;
    logic                   re;
    logic [IDX_W-1:0]       addr;
    logic [DATA_WIDTH-1:0]  wdata;
  } deq_mem_cmd_t;

  typedef struct packed {
    logic              valid;
    logic              pop;
    status_e           status;
    logic [CNT_W-1:0]  occupancy;
  } deq_rslt_t;

endpackage

>>> hdl/deq_ram.sv
// Generic single-port synchronous RAM with a registered read.
module deq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

>>> hdl/deq_ctrl.sv
// Index and count control of the double-ended queue, with the result register.
module deq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   accept_i,
  input  deq_pkg::deq_req_t      req_i,
  output deq_pkg::deq_mem_cmd_t  mem_o,
  output deq_pkg::deq_rslt_t     rslt_o
);

  logic [deq_pkg::IDX_W-1:0] front_q, front_d;
  logic [deq_pkg::CNT_W-1:0] count_q, count_d;
  deq_pkg::deq_rslt_t        rslt_q, rslt_d;

  logic                      full, empty;
  logic [deq_pkg::IDX_W-1:0] front_dec, front_inc, rear_idx, last_idx;
  logic [deq_pkg::SUM_W-1:0] rear_sum, last_sum;

  assign full  = (count_q == deq_pkg::FULL_CNT);
  assign empty = (count_q == '0);

  assign front_dec = (front_q == '0) ? deq_pkg::LAST_IDX : front_q - 1'b1;
  assign front_inc = (front_q == deq_pkg::LAST_IDX) ? '0 : front_q + 1'b1;

  assign rear_sum = deq_pkg::SUM_W'(front_q) + deq_pkg::SUM_W'(count_q);
  assign last_sum = rear_sum - 1'b1;
  assign rear_idx = (rear_sum >= deq_pkg::DEPTH_SUM) ?
                    deq_pkg::IDX_W'(rear_sum - deq_pkg::DEPTH_SUM) :
                    rear_sum[deq_pkg::IDX_W-1:0];
  assign last_idx = (last_sum >= deq_pkg::DEPTH_SUM) ?
                    deq_pkg::IDX_W'(last_sum - deq_pkg::DEPTH_SUM) :
                    last_sum[deq_pkg::IDX_W-1:0];

  always_comb begin
    front_d          = front_q;
    count_d          = count_q;
    mem_o.we         = 1'b0;
    mem_o.re         = 1'b0;
    mem_o.addr       = front_q;
    mem_o.wdata      = req_i.push_value;
    rslt_d.valid     = accept_i;
    rslt_d.pop       = 1'b0;
    rslt_d.status    = deq_pkg::ST_OK;
    rslt_d.occupancy = count_q;
    if (accept_i) begin
      case (req_i.op)
        deq_pkg::OP_PUSH_FRONT: begin
          if (full) begin
            rslt_d.status = deq_pkg::ST_FULL;
          end else begin
            mem_o.we   = 1'b1;
            mem_o.addr = front_dec;
            front_d    = front_dec;
            count_d    = count_q + 1'b1;
          end
        end
        deq_pkg::OP_PUSH_REAR: begin
          if (full) begin
            rslt_d.status = deq_pkg::ST_FULL;
          end else begin
            mem_o.we   = 1'b1;
            mem_o.addr = rear_idx;
            count_d    = count_q + 1'b1;
          end
        end
        deq_pkg::OP_POP_FRONT: begin
          if (empty) begin
            rslt_d.status = deq_pkg::ST_EMPTY;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.addr  = front_q;
            rslt_d.pop  = 1'b1;
            front_d     = front_inc;
            count_d     = count_q - 1'b1;
          end
        end
        deq_pkg::OP_POP_REAR: begin
          if (empty) begin
            rslt_d.status = deq_pkg::ST_EMPTY;
          end else begin
            mem_o.re    = 1'b1;
            mem_o.addr  = last_idx;
            rslt_d.pop  = 1'b1;
            count_d     = count_q - 1'b1;
          end
        end
        default: begin
          rslt_d.status = deq_pkg::ST_OK;
        end
      endcase
    end
    rslt_d.occupancy = count_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      front_q <= '0;
      count_q <= '0;
      rslt_q  <= '0;
    end else begin
      front_q <= front_d;
      count_q <= count_d;
      rslt_q  <= rslt_d;
    end
  end

  assign rslt_o = rslt_q;

`ifndef SYNTHESIS
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    count_q <= deq_pkg::FULL_CNT)
    else $error("Entry count exceeds the queue depth.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept_i |=> rslt_q.valid)
    else $error("An accepted transaction produced no result.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (accept_i && full && (req_i.op == deq_pkg::OP_PUSH_FRONT ||
                          req_i.op == deq_pkg::OP_PUSH_REAR))
    |=> (count_q == $past(count_q) && front_q == $past(front_q) &&
         rslt_q.status == deq_pkg::ST_FULL))
    else $error("A push into a full queue changed the state.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rslt_q.valid |-> (rslt_q.occupancy == count_q))
    else $error("Reported occupancy differs from the entry count.");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (mem_o.we || mem_o.re) |-> accept_i)
    else $error("Memory accessed without an accepted transaction.");
`endif

endmodule

>>> hdl/double_ended_queue.sv
// Top level of the bounded double-ended queue of signed words.
//
// A request is a transaction on the command channel: it is taken at a rising
// clock edge where start is high and busy is low. Its payload carries the
// operation (push front, push rear, pop front, pop rear) and the value to push.
// Every request yields exactly one result on rsp_o, marked by done_o for one
// cycle, in the cycle after the request was taken. The result holds the popped
// value (zero on pushes and failed pops), a status of ok, empty or full, and
// the occupancy after the request.
// The entries live in a single-port memory with a registered read; a request
// reads or writes it at most once, in the cycle it is taken; a new request may
// follow in every cycle. Busy stays low.
// Reset clears the front index and the entry count, so the queue starts empty;
// the memory contents are not cleared. The receiver cannot stall: a result is
// valid only in the cycle where done_o is high.
module double_ended_queue (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  deq_pkg::deq_req_t  req_i,
  output logic               done_o,
  output deq_pkg::deq_rsp_t  rsp_o
);

  deq_pkg::deq_mem_cmd_t             mem_cmd;
  deq_pkg::deq_rslt_t                rslt;
  logic [deq_pkg::DATA_WIDTH-1:0]    rdata;
  logic                              accept;

  assign busy   = 1'b0;
  assign accept = start && !busy;

  deq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .req_i    (req_i),
    .mem_o    (mem_cmd),
    .rslt_o   (rslt)
  );

  deq_ram #(
    .WIDTH (deq_pkg::DATA_WIDTH),
    .DEPTH (deq_pkg::DEPTH)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (mem_cmd.we),
    .re_i    (mem_cmd.re),
    .addr_i  (mem_cmd.addr),
    .wdata_i (mem_cmd.wdata),
    .rdata_o (rdata)
  );

  assign done_o          = rslt.valid;
  assign rsp_o.pop_value = rslt.pop ? rdata : '0;
  assign rsp_o.status    = rslt.status;
  assign rsp_o.occupancy = rslt.occupancy;

endmodule

>>> tb/sv/tb_double_ended_queue.sv
// Self-checking testbench of the double-ended queue: directed corner cases and random traffic.
module tb_double_ended_queue;

  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 5;
  localparam logic signed [deq_pkg::DATA_WIDTH-1:0] WORD_MIN =
    {1'b1, {(deq_pkg::DATA_WIDTH-1){1'b0}}};
  localparam logic signed [deq_pkg::DATA_WIDTH-1:0] WORD_MAX =
    {1'b0, {(deq_pkg::DATA_WIDTH-1){1'b1}}};

  logic               clk_i;
  logic               rst_ni = 1'b0;
  logic               start  = 1'b0;
  logic               busy;
  deq_pkg::deq_req_t  req_i  = '0;
  logic               done_o;
  deq_pkg::deq_rsp_t  rsp_o;

  logic signed [deq_pkg::DATA_WIDTH-1:0] shadow_words [deq_pkg::DEPTH];
  logic [deq_pkg::IDX_W-1:0]             shadow_front = '0;
  logic [deq_pkg::CNT_W-1:0]             shadow_count = '0;

  deq_pkg::deq_rsp_t pending_rsp [$];
  deq_pkg::deq_rsp_t oldest_rsp;
  int                errors       = 0;
  int                stall_cycles = 0;
  int                idle_pct     = 0;

  double_ended_queue uut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .busy   (busy),
    .req_i  (req_i),
    .done_o (done_o),
    .rsp_o  (rsp_o)
  );

  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  function automatic deq_pkg::deq_rsp_t deque_apply(deq_pkg::deq_req_t r);
    deq_pkg::deq_rsp_t rsp;
    rsp.pop_value = '0;
    rsp.status    = deq_pkg::ST_OK;
    case (r.op)
      deq_pkg::OP_PUSH_FRONT, deq_pkg::OP_PUSH_REAR: begin
        if (shadow_count == deq_pkg::FULL_CNT) begin
          rsp.status = deq_pkg::ST_FULL;
        end else if (r.op == deq_pkg::OP_PUSH_FRONT) begin
          shadow_front               = shadow_front - 1'b1;
          shadow_words[shadow_front] = r.push_value;
          shadow_count               = shadow_count + 1'b1;
        end else begin
          shadow_words[deq_pkg::IDX_W'(shadow_front + shadow_count)] = r.push_value;
          shadow_count = shadow_count + 1'b1;
        end
      end
      default: begin
        if (shadow_count == '0) begin
          rsp.status = deq_pkg::ST_EMPTY;
        end else if (r.op == deq_pkg::OP_POP_FRONT) begin
          rsp.pop_value = shadow_words[shadow_front];
          shadow_front  = shadow_front + 1'b1;
          shadow_count  = shadow_count - 1'b1;
        end else begin
          rsp.pop_value =
            shadow_words[deq_pkg::IDX_W'(shadow_front + shadow_count - 1)];
          shadow_count  = shadow_count - 1'b1;
        end
      end
    endcase
    rsp.occupancy = shadow_count;
    return rsp;
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (done_o) begin
        if (pending_rsp.size() == 0) begin
          $error("result with no request outstanding");
          errors++;
        end else begin
          oldest_rsp = pending_rsp.pop_front();
          if (rsp_o.pop_value !== oldest_rsp.pop_value) begin
            $error("pop_value: expected %0d, actual %0d", oldest_rsp.pop_value,
                   rsp_o.pop_value);
            errors++;
          end
          if (rsp_o.status !== oldest_rsp.status) begin
            $error("status: expected %0d, actual %0d", oldest_rsp.status, rsp_o.status);
            errors++;
          end
          if (rsp_o.occupancy !== oldest_rsp.occupancy) begin
            $error("occupancy: expected %0d, actual %0d", oldest_rsp.occupancy,
                   rsp_o.occupancy);
            errors++;
          end
        end
      end
      if (start && !busy) begin
        pending_rsp.push_back(deque_apply(req_i));
      end
      if ((start && !busy) || done_o) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
      end
      if (stall_cycles >= WATCHDOG_LIMIT) begin
        $display("FAIL");
        $finish;
      end
    end
  end

  task automatic send(deq_pkg::op_e op, logic signed [deq_pkg::DATA_WIDTH-1:0] value);
    start <= 1'b1;
    req_i <= '{op: op, push_value: value};
    @(posedge clk_i);
    while (busy) begin
      @(posedge clk_i);
    end
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
  endtask

  task automatic wait_drained();
    start <= 1'b0;
    @(posedge clk_i);
    while (pending_rsp.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  function automatic logic signed [deq_pkg::DATA_WIDTH-1:0] pick_word();
    case ($urandom_range(7))
      0:       return WORD_MIN;
      1:       return WORD_MAX;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic test_empty_pops();
    send(deq_pkg::OP_POP_FRONT, WORD_MAX);
    send(deq_pkg::OP_POP_REAR, WORD_MIN);
  endtask

  task automatic test_extremes();
    send(deq_pkg::OP_PUSH_FRONT, WORD_MIN);
    send(deq_pkg::OP_PUSH_REAR, WORD_MAX);
    send(deq_pkg::OP_POP_REAR, '0);
    send(deq_pkg::OP_POP_FRONT, '1);
  endtask

  task automatic test_fill_to_full();
    for (int i = 0; i < deq_pkg::DEPTH; i++) begin
      send(i[0] ? deq_pkg::OP_PUSH_REAR : deq_pkg::OP_PUSH_FRONT,
           (i % 3 == 0) ? '1 : deq_pkg::DATA_WIDTH'(i));
    end
    send(deq_pkg::OP_PUSH_FRONT, WORD_MAX);
    send(deq_pkg::OP_PUSH_REAR, WORD_MIN);
  endtask

  task automatic test_random_traffic(int n_items);
    int sent;
    int burst;
    int push_pct;
    sent = 0;
    while (sent < n_items) begin
      burst = $urandom_range(4, 40);
      case ($urandom_range(2))
        0:       push_pct = 85;
        1:       push_pct = 15;
        default: push_pct = 50;
      endcase
      for (int i = 0; i < burst && sent < n_items; i++) begin
        if ($urandom_range(99) < push_pct) begin
          send($urandom_range(1) ? deq_pkg::OP_PUSH_FRONT : deq_pkg::OP_PUSH_REAR,
               pick_word());
        end else begin
          send($urandom_range(1) ? deq_pkg::OP_POP_FRONT : deq_pkg::OP_POP_REAR,
               pick_word());
        end
        sent++;
      end
    end
  endtask

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    idle_pct = 9;
    test_empty_pops();
    test_extremes();
    test_fill_to_full();
    test_random_traffic(375);
    wait_drained();
    idle_pct = 59;
    test_random_traffic(375);
    wait_drained();
    idle_pct = 0;
    test_random_traffic(376);
    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (errors == 0 && pending_rsp.size() == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> double_ended_queue.f
hdl/deq_pkg.sv
hdl/deq_ram.sv
hdl/deq_ctrl.sv
hdl/double_ended_queue.sv
tb/sv/tb_double_ended_queue.sv
